[rtl/tssrs_pkg.sv]
// Shared types, constants and saturation helper for the two-store synapse step unit.
`timescale 1ns / 1ps

package tssrs_pkg;

  // Saturation width of concentrations and rate (full scale is 2^DATA_WIDTH-1, capped at 32 bits)
  localparam int DATA_WIDTH = 32;

  // Field and arithmetic widths
  localparam int VAL_W   = 32;          // Q16.16 values and Q0.32 gains
  localparam int PROD_W  = 2 * VAL_W;   // raw product of the shared multiplier
  localparam int FRAC_W  = 16;          // fraction bits of Q16.16
  localparam int QPROD_W = PROD_W - FRAC_W;
  localparam int SUM_W   = 51;          // signed step sums and gain products
  localparam int NEW_W   = 53;          // signed updated concentration before clamp
  localparam int CFG_IDX_W = 3;

  localparam logic [VAL_W-1:0] FULL_SCALE =
    (DATA_WIDTH >= VAL_W) ? {VAL_W{1'b1}} : VAL_W'((64'd1 << DATA_WIDTH) - 64'd1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_OVER_VI        = 3'd0,
    REG_STEP_OVER_VL        = 3'd1,
    REG_RELEASE_PERM        = 3'd2,
    REG_GLOBAL_PERM         = 3'd3,
    REG_GLOBAL_CONC         = 3'd4,
    REG_REST_IMMEDIATE_CONC = 3'd5,
    REG_REST_LOCAL_CONC     = 3'd6,
    REG_REST_PERM           = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [VAL_W-1:0] step_over_vi;
    logic [VAL_W-1:0] step_over_vl;
    logic [VAL_W-1:0] release_perm;
    logic [VAL_W-1:0] global_perm;
    logic [VAL_W-1:0] global_conc;
    logic [VAL_W-1:0] rest_immediate_conc;
    logic [VAL_W-1:0] rest_local_conc;
    logic [VAL_W-1:0] rest_perm;
  } cfg_t;

  typedef struct packed {
    logic [VAL_W-1:0] ppi;
    logic             restart;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] rate;
    logic             clipped;
  } result_t;

  // Sequencer states: one multiply issued per state from ST_MA to ST_MH
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MA,    // issue last_perm * ci
    ST_MB,    // issue release_perm * |cl-ci|
    ST_MC,    // issue global_perm * |cg-cl|
    ST_MD,    // issue gain_i * low word of |s_i|
    ST_ME,    // issue gain_i * high word of |s_i|
    ST_MF,    // issue gain_l * low word of |s_l|
    ST_MG,    // issue gain_l * high word of |s_l|, update ci
    ST_MH,    // issue new ci * ppi
    ST_MI,    // update cl, clamp rate
    ST_DONE
  } state_t;

  // Clamp a signed value to [0, FULL_SCALE]; bit VAL_W of the result is the clip flag
  function automatic logic [VAL_W:0] sat_value(input logic signed [NEW_W-1:0] v);
    logic [VAL_W:0] res;
    res = {1'b0, v[VAL_W-1:0]};
    if (v < 0) begin
      res = {1'b1, {VAL_W{1'b0}}};
    end else if (v > $signed({{(NEW_W-VAL_W){1'b0}}, FULL_SCALE})) begin
      res = {1'b1, FULL_SCALE};
    end
    return res;
  endfunction

endpackage

[rtl/tssrs_mul.sv]
// Shared 32x32 unsigned multiplier with registered product.
`timescale 1ns / 1ps

module tssrs_mul (
  input  logic                          clk,
  input  logic [tssrs_pkg::VAL_W-1:0]   a,
  input  logic [tssrs_pkg::VAL_W-1:0]   b,
  output logic [tssrs_pkg::PROD_W-1:0]  p
);

  logic [tssrs_pkg::PROD_W-1:0] prod_r;
  logic [tssrs_pkg::PROD_W-1:0] prod_nxt;

  // Full-width product of the operands issued this cycle
  assign prod_nxt = tssrs_pkg::PROD_W'(a) * tssrs_pkg::PROD_W'(b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign p = prod_r;

endmodule

[rtl/tssrs_core.sv]
// Step sequencer, store state and accumulators around the shared multiplier.
`timescale 1ns / 1ps

module tssrs_core (
  input  logic                clk,
  input  logic                rst_n,
  input  tssrs_pkg::cfg_t     cfg,
  input  logic                start,
  input  tssrs_pkg::in_item_t item,
  output logic                idle,
  output logic                res_valid,
  input  logic                res_ready,
  output tssrs_pkg::result_t  res
);

  localparam int VW = tssrs_pkg::VAL_W;
  localparam int SW = tssrs_pkg::SUM_W;
  localparam int NW = tssrs_pkg::NEW_W;
  localparam int PW = tssrs_pkg::PROD_W;
  localparam int QW = tssrs_pkg::QPROD_W;

  tssrs_pkg::state_t state_r, state_nxt;

  logic [VW-1:0]        ci_r, ci_nxt;
  logic [VW-1:0]        cl_r, cl_nxt;
  logic [VW-1:0]        perm_r, perm_nxt;
  logic [VW-1:0]        ppi_r, ppi_nxt;
  logic signed [SW-1:0] si_r, si_nxt;
  logic signed [SW-1:0] sl_r, sl_nxt;
  logic [VW-1:0]        lo_r, lo_nxt;
  logic [SW-1:0]        mi_r, mi_nxt;
  logic [SW-1:0]        ml_r, ml_nxt;
  logic [VW-1:0]        rate_r, rate_nxt;
  logic                 clip_r, clip_nxt;

  logic [VW-1:0]        mul_a, mul_b;
  logic [PW-1:0]        prod;

  logic                 d_neg, e_neg;
  logic [VW-1:0]        d_mag, e_mag;
  logic signed [SW-1:0] prod_sx;
  logic [SW-1:0]        si_mag, sl_mag;
  logic signed [NW-1:0] ci_upd, cl_upd;
  logic [VW:0]          ci_sat, cl_sat;
  logic                 rate_over;

  tssrs_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Differences, magnitudes and clamps feeding the sequence
  always_comb begin
    d_neg   = cl_r < ci_r;
    d_mag   = d_neg ? (ci_r - cl_r) : (cl_r - ci_r);
    e_neg   = cfg.global_conc < cl_r;
    e_mag   = e_neg ? (cl_r - cfg.global_conc) : (cfg.global_conc - cl_r);
    prod_sx = $signed({{(SW-QW){1'b0}}, prod[PW-1:tssrs_pkg::FRAC_W]});
    si_mag  = si_r[SW-1] ? SW'(-si_r) : SW'(si_r);
    sl_mag  = sl_r[SW-1] ? SW'(-sl_r) : SW'(sl_r);
    ci_upd  = si_r[SW-1]
            ? $signed({{(NW-VW){1'b0}}, ci_r}) - $signed({{(NW-SW){1'b0}}, mi_r})
            : $signed({{(NW-VW){1'b0}}, ci_r}) + $signed({{(NW-SW){1'b0}}, mi_r});
    cl_upd  = sl_r[SW-1]
            ? $signed({{(NW-VW){1'b0}}, cl_r}) - $signed({{(NW-SW){1'b0}}, ml_r})
            : $signed({{(NW-VW){1'b0}}, cl_r}) + $signed({{(NW-SW){1'b0}}, ml_r});
    ci_sat  = tssrs_pkg::sat_value(ci_upd);
    cl_sat  = tssrs_pkg::sat_value(cl_upd);
    rate_over = prod[PW-1:tssrs_pkg::FRAC_W] > {{(QW-VW){1'b0}}, tssrs_pkg::FULL_SCALE};
  end

  // Next state, operand selection and accumulator updates
  always_comb begin
    state_nxt = state_r;
    ci_nxt    = ci_r;
    cl_nxt    = cl_r;
    perm_nxt  = perm_r;
    ppi_nxt   = ppi_r;
    si_nxt    = si_r;
    sl_nxt    = sl_r;
    lo_nxt    = lo_r;
    mi_nxt    = mi_r;
    ml_nxt    = ml_r;
    rate_nxt  = rate_r;
    clip_nxt  = clip_r;
    mul_a     = '0;
    mul_b     = '0;
    idle      = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      tssrs_pkg::ST_IDLE: begin
        idle = 1'b1;
        if (start) begin
          ppi_nxt  = item.ppi;
          clip_nxt = 1'b0;
          if (item.restart) begin
            ci_nxt   = cfg.rest_immediate_conc;
            cl_nxt   = cfg.rest_local_conc;
            perm_nxt = cfg.rest_perm;
          end
          state_nxt = tssrs_pkg::ST_MA;
        end
      end
      tssrs_pkg::ST_MA: begin
        mul_a     = perm_r;
        mul_b     = ci_r;
        state_nxt = tssrs_pkg::ST_MB;
      end
      tssrs_pkg::ST_MB: begin
        // s_i starts as the release loss
        si_nxt    = -prod_sx;
        mul_a     = cfg.release_perm;
        mul_b     = d_mag;
        state_nxt = tssrs_pkg::ST_MC;
      end
      tssrs_pkg::ST_MC: begin
        // Diffusion between local and immediate stores, opposite signs
        si_nxt    = si_r + (d_neg ? -prod_sx : prod_sx);
        sl_nxt    = d_neg ? prod_sx : -prod_sx;
        mul_a     = cfg.global_perm;
        mul_b     = e_mag;
        state_nxt = tssrs_pkg::ST_MD;
      end
      tssrs_pkg::ST_MD: begin
        sl_nxt    = sl_r + (e_neg ? -prod_sx : prod_sx);
        mul_a     = cfg.step_over_vi;
        mul_b     = si_mag[VW-1:0];
        state_nxt = tssrs_pkg::ST_ME;
      end
      tssrs_pkg::ST_ME: begin
        lo_nxt    = prod[PW-1:VW];
        mul_a     = cfg.step_over_vi;
        mul_b     = VW'(si_mag[SW-1:VW]);
        state_nxt = tssrs_pkg::ST_MF;
      end
      tssrs_pkg::ST_MF: begin
        mi_nxt    = SW'(prod) + {{(SW-VW){1'b0}}, lo_r};
        mul_a     = cfg.step_over_vl;
        mul_b     = sl_mag[VW-1:0];
        state_nxt = tssrs_pkg::ST_MG;
      end
      tssrs_pkg::ST_MG: begin
        lo_nxt    = prod[PW-1:VW];
        ci_nxt    = ci_sat[VW-1:0];
        clip_nxt  = clip_r | ci_sat[VW];
        mul_a     = cfg.step_over_vl;
        mul_b     = VW'(sl_mag[SW-1:VW]);
        state_nxt = tssrs_pkg::ST_MH;
      end
      tssrs_pkg::ST_MH: begin
        ml_nxt    = SW'(prod) + {{(SW-VW){1'b0}}, lo_r};
        mul_a     = ci_r;
        mul_b     = ppi_r;
        state_nxt = tssrs_pkg::ST_MI;
      end
      tssrs_pkg::ST_MI: begin
        cl_nxt    = cl_sat[VW-1:0];
        rate_nxt  = rate_over ? tssrs_pkg::FULL_SCALE : prod[tssrs_pkg::FRAC_W +: VW];
        clip_nxt  = clip_r | cl_sat[VW] | rate_over;
        perm_nxt  = ppi_r;
        state_nxt = tssrs_pkg::ST_DONE;
      end
      tssrs_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = tssrs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tssrs_pkg::ST_IDLE;
      end
    endcase
  end

  // State and store registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tssrs_pkg::ST_IDLE;
      ci_r    <= '0;
      cl_r    <= '0;
      perm_r  <= '0;
      clip_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ci_r    <= ci_nxt;
      cl_r    <= cl_nxt;
      perm_r  <= perm_nxt;
      clip_r  <= clip_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    ppi_r  <= ppi_nxt;
    si_r   <= si_nxt;
    sl_r   <= sl_nxt;
    lo_r   <= lo_nxt;
    mi_r   <= mi_nxt;
    ml_r   <= ml_nxt;
    rate_r <= rate_nxt;
  end

  assign res.rate    = rate_r;
  assign res.clipped = clip_r;

  a_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> state_r == tssrs_pkg::ST_MA)
    else $error("accepted beat did not start the step sequence");

  a_done_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tssrs_pkg::ST_DONE |->
      (ci_r <= tssrs_pkg::FULL_SCALE && cl_r <= tssrs_pkg::FULL_SCALE))
    else $error("stored concentration above full scale after a step");

  a_perm_kept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tssrs_pkg::ST_DONE |-> perm_r == ppi_r)
    else $error("last permeability not written back");

  a_res_after_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(res_valid) |-> $past(state_r) == tssrs_pkg::ST_MI)
    else $error("result shown without finishing the sequence");

endmodule

[rtl/two_store_synapse_release_step_unit.sv]
// Top level: configuration registers, stream ports and output register of the synapse step.
//
//  channel | dir  | beat contents
//  in_     | in   | tdata[31:0] ppi, tuser[0] restart
//  out_    | out  | tdata[31:0] rate, tuser[0] clipped
//  cfg_    | in   | wr_en, index[2:0], wdata[31:0]
//
// Each beat passes from acceptance to the next acceptance through the idle state that
// takes it, states ST_MA to ST_MH issuing products to the single 32x32 multiplier, ST_MI
// collecting the last product and ST_DONE handing the result to the output register.
// in_tready is high only while the sequencer is idle.
// A finished result sits in the output register while the next beat is taken; a
// stalled output holds the sequencer at its last step until the register frees.
// rst_n is synchronous; it clears the registers, the stores, the sequencer and out_tvalid.
`timescale 1ns / 1ps

module two_store_synapse_release_step_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tssrs_pkg::VAL_W-1:0]         in_tdata,   // [31:0] ppi
  input  logic                                in_tuser,   // [0] restart
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tssrs_pkg::VAL_W-1:0]         out_tdata,  // [31:0] rate
  output logic                                out_tuser,  // [0] clipped
  input  logic                                cfg_wr_en,
  input  logic [tssrs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tssrs_pkg::VAL_W-1:0]         cfg_wdata
);

  tssrs_pkg::cfg_t     cfg_r, cfg_nxt;
  tssrs_pkg::in_item_t item;
  tssrs_pkg::result_t  res;
  tssrs_pkg::result_t  out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                idle, start, res_valid, res_ready;

  // Register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (tssrs_pkg::reg_idx_t'(cfg_index))
        tssrs_pkg::REG_STEP_OVER_VI:        cfg_nxt.step_over_vi        = cfg_wdata;
        tssrs_pkg::REG_STEP_OVER_VL:        cfg_nxt.step_over_vl        = cfg_wdata;
        tssrs_pkg::REG_RELEASE_PERM:        cfg_nxt.release_perm        = cfg_wdata;
        tssrs_pkg::REG_GLOBAL_PERM:         cfg_nxt.global_perm         = cfg_wdata;
        tssrs_pkg::REG_GLOBAL_CONC:         cfg_nxt.global_conc         = cfg_wdata;
        tssrs_pkg::REG_REST_IMMEDIATE_CONC: cfg_nxt.rest_immediate_conc = cfg_wdata;
        tssrs_pkg::REG_REST_LOCAL_CONC:     cfg_nxt.rest_local_conc     = cfg_wdata;
        tssrs_pkg::REG_REST_PERM:           cfg_nxt.rest_perm           = cfg_wdata;
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  // Input side
  assign in_tready    = idle;
  assign start        = in_tvalid && idle;
  assign item.ppi     = in_tdata;
  assign item.restart = in_tuser;

  tssrs_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (start),
    .item      (item),
    .idle      (idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: load when empty or being drained
  always_comb begin
    res_ready     = !out_valid_r || out_tready;
    out_valid_nxt = out_valid_r && !out_tready;
    out_nxt       = out_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.rate;
  assign out_tuser  = out_r.clipped;

endmodule

[verif/two_store_synapse_release_step_unit_test.sv]
// Self-checking stream testbench for the two-store synapse release step unit.
`timescale 1ns / 1ps

module two_store_synapse_release_step_unit_test;

  localparam int RANDOM_BEATS = 1030;
  localparam int HOLD_CYCLES  = 64;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PRINT_LIMIT  = 100;

  localparam int VAL_W  = tssrs_pkg::VAL_W;
  localparam int FRAC_W = tssrs_pkg::FRAC_W;
  localparam logic [VAL_W-1:0] FULL_SCALE = tssrs_pkg::FULL_SCALE;

  typedef enum {ROW_WRITE, ROW_BEAT, ROW_KNOWN} row_kind_t;
  typedef enum {STYLE_TAME, STYLE_EXTREME, STYLE_WILD} cfg_style_t;

  // idx only matters for ROW_WRITE; word is wdata for writes and ppi for beats
  typedef struct {
    row_kind_t           kind;
    tssrs_pkg::reg_idx_t idx;
    logic [VAL_W-1:0]    word;
    logic                restart;
    tssrs_pkg::result_t  known;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [VAL_W-1:0]    in_tdata = '0;   // [31:0] ppi
  logic                in_tuser = 1'b0; // [0] restart
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [VAL_W-1:0]    out_tdata;       // [31:0] rate
  logic                out_tuser;       // [0] clipped
  logic                cfg_wr_en = 1'b0;
  tssrs_pkg::reg_idx_t cfg_index = tssrs_pkg::REG_STEP_OVER_VI;
  logic [VAL_W-1:0]    cfg_wdata = '0;

  // typed-in expectation travelling with the current input beat
  bit                 pin_known = 1'b0;
  tssrs_pkg::result_t pin_result = '0;

  // predictor copy of the registers and the stores
  tssrs_pkg::cfg_t    syn_cfg;
  logic [VAL_W-1:0]   imm_conc, loc_conc, prev_perm;
  tssrs_pkg::result_t pending_rates[$];

  plan_row_t plan[$];
  int        error_count = 0;
  int        result_no = 0;
  int        cycle_count = 0;
  int        stall_left = 0;
  bit        hold_req = 1'b0;
  bit        hold_taken = 1'b0;
  bit        calm = 1'b1;

  two_store_synapse_release_step_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Q16.16 permeability times a signed difference, truncated toward zero
  function automatic longint perm_mul(input logic [VAL_W-1:0] g, input longint v);
    logic [63:0] mag, p;
    mag = (v < 0) ? -v : v;
    p = ({32'd0, g} * mag) >> FRAC_W;
    return (v < 0) ? -longint'(p) : longint'(p);
  endfunction

  // Q0.32 gain times a signed sum below 2^50, split in two words, truncated toward zero
  function automatic longint gain_mul(input logic [VAL_W-1:0] g, input longint v);
    logic [63:0] mag, p;
    mag = (v < 0) ? -v : v;
    p = {32'd0, g} * {32'd0, mag[63:32]} + (({32'd0, g} * {32'd0, mag[31:0]}) >> 32);
    return (v < 0) ? -longint'(p) : longint'(p);
  endfunction

  // clamp to [0, full scale]; top bit set when clamped
  function automatic logic [VAL_W:0] clamp_conc(input longint v);
    if (v < 0) return {1'b1, {VAL_W{1'b0}}};
    if (v > longint'({32'd0, FULL_SCALE})) return {1'b1, FULL_SCALE};
    return {1'b0, v[VAL_W-1:0]};
  endfunction

  // one forward-Euler step of both stores, then the release rate
  function automatic tssrs_pkg::result_t euler_release_step(input logic [VAL_W-1:0] ppi,
                                                            input logic restart);
    longint             ci, cl, diff, s_i, s_l;
    logic [VAL_W:0]     ci_c, cl_c;
    logic [63:0]        rate_w;
    tssrs_pkg::result_t r;
    if (restart) begin
      imm_conc  = syn_cfg.rest_immediate_conc;
      loc_conc  = syn_cfg.rest_local_conc;
      prev_perm = syn_cfg.rest_perm;
    end
    ci = longint'({32'd0, imm_conc});
    cl = longint'({32'd0, loc_conc});
    diff = cl - ci;
    s_i = perm_mul(syn_cfg.release_perm, diff) - perm_mul(prev_perm, ci);
    s_l = perm_mul(syn_cfg.global_perm, longint'({32'd0, syn_cfg.global_conc}) - cl)
          - perm_mul(syn_cfg.release_perm, diff);
    ci_c = clamp_conc(ci + gain_mul(syn_cfg.step_over_vi, s_i));
    cl_c = clamp_conc(cl + gain_mul(syn_cfg.step_over_vl, s_l));
    rate_w = ({32'd0, ci_c[VAL_W-1:0]} * {32'd0, ppi}) >> FRAC_W;
    r.clipped = ci_c[VAL_W] | cl_c[VAL_W];
    if (rate_w > {32'd0, FULL_SCALE}) begin
      r.rate = FULL_SCALE;
      r.clipped = 1'b1;
    end else begin
      r.rate = rate_w[VAL_W-1:0];
    end
    imm_conc  = ci_c[VAL_W-1:0];
    loc_conc  = cl_c[VAL_W-1:0];
    prev_perm = ppi;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [VAL_W-1:0] got,
                               input logic [VAL_W-1:0] want);
    if (error_count < PRINT_LIMIT)
      $display("MISMATCH result %0d %s: got 0x%08h want 0x%08h", result_no, what, got, want);
    error_count++;
  endtask

  function automatic void plan_add(input row_kind_t kind, input tssrs_pkg::reg_idx_t idx,
                                   input logic [VAL_W-1:0] word, input logic restart,
                                   input logic [VAL_W-1:0] rate, input logic clipped);
    plan_row_t row;
    row.kind = kind;
    row.idx = idx;
    row.word = word;
    row.restart = restart;
    row.known.rate = rate;
    row.known.clipped = clipped;
    plan.push_back(row);
  endfunction

  // offer one beat and hold it until the handshake edge
  task automatic send_beat(input logic [VAL_W-1:0] ppi, input logic restart,
                           input bit known, input tssrs_pkg::result_t want);
    @(negedge clk);
    in_tvalid  <= 1'b1;
    in_tdata   <= ppi;
    in_tuser   <= restart;
    pin_known  <= known;
    pin_result <= want;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(input tssrs_pkg::reg_idx_t idx, input logic [VAL_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // drop valid and wait until every outstanding rate has come back
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_rates.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Predict on input beats and register writes, check output beats in order
  always @(posedge clk) begin : scoreboard
    tssrs_pkg::result_t want, predicted;
    if (!rst_n) begin
      syn_cfg = '0;
      imm_conc = '0;
      loc_conc = '0;
      prev_perm = '0;
      pending_rates.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        result_no++;
        if (pending_rates.size() == 0) begin
          flag_mismatch("result with nothing expected", out_tdata, '0);
        end else begin
          want = pending_rates.pop_front();
          if (out_tdata !== want.rate) flag_mismatch("rate", out_tdata, want.rate);
          if (out_tuser !== want.clipped)
            flag_mismatch("clipped", {31'd0, out_tuser}, {31'd0, want.clipped});
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          tssrs_pkg::REG_STEP_OVER_VI:        syn_cfg.step_over_vi = cfg_wdata;
          tssrs_pkg::REG_STEP_OVER_VL:        syn_cfg.step_over_vl = cfg_wdata;
          tssrs_pkg::REG_RELEASE_PERM:        syn_cfg.release_perm = cfg_wdata;
          tssrs_pkg::REG_GLOBAL_PERM:         syn_cfg.global_perm = cfg_wdata;
          tssrs_pkg::REG_GLOBAL_CONC:         syn_cfg.global_conc = cfg_wdata;
          tssrs_pkg::REG_REST_IMMEDIATE_CONC: syn_cfg.rest_immediate_conc = cfg_wdata;
          tssrs_pkg::REG_REST_LOCAL_CONC:     syn_cfg.rest_local_conc = cfg_wdata;
          tssrs_pkg::REG_REST_PERM:           syn_cfg.rest_perm = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        predicted = euler_release_step(in_tdata, in_tuser);
        pending_rates.push_back(pin_known ? pin_result : predicted);
      end
    end
  end

  // Result sink: one long hold-off on request, otherwise short random stall bursts
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rates outstanding", cycle_count,
               pending_rates.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t        row;
    cfg_style_t       style;
    logic [VAL_W-1:0] word;
    logic             restart;
    int               sent, phase_len, gap;

    // Idle after reset: every register and store is zero
    plan_add(ROW_KNOWN, tssrs_pkg::REG_STEP_OVER_VI, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0);
    plan_add(ROW_KNOWN, tssrs_pkg::REG_STEP_OVER_VI, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0);
    // Zero gains hold the stores, so the rate is the rest level times ppi
    plan_add(ROW_WRITE, tssrs_pkg::REG_REST_IMMEDIATE_CONC, 32'h0001_0000, 1'b0, '0, 1'b0);
    plan_add(ROW_KNOWN, tssrs_pkg::REG_STEP_OVER_VI, 32'h0001_0000, 1'b1, 32'h0001_0000, 1'b0);
    plan_add(ROW_KNOWN, tssrs_pkg::REG_STEP_OVER_VI, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0);
    plan_add(ROW_KNOWN, tssrs_pkg::REG_STEP_OVER_VI, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0);
    // Rate overflow at full-scale level and ppi
    plan_add(ROW_WRITE, tssrs_pkg::REG_REST_IMMEDIATE_CONC, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
    plan_add(ROW_KNOWN, tssrs_pkg::REG_STEP_OVER_VI, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
    plan_add(ROW_KNOWN, tssrs_pkg::REG_STEP_OVER_VI, 32'h0000_0001, 1'b0, 32'h0000_FFFF, 1'b0);
    // Immediate store underflow: huge last permeability drains it below zero
    plan_add(ROW_WRITE, tssrs_pkg::REG_STEP_OVER_VI, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
    plan_add(ROW_WRITE, tssrs_pkg::REG_REST_PERM, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
    plan_add(ROW_WRITE, tssrs_pkg::REG_REST_IMMEDIATE_CONC, 32'h0001_0000, 1'b0, '0, 1'b0);
    plan_add(ROW_KNOWN, tssrs_pkg::REG_STEP_OVER_VI, 32'h1234_5678, 1'b1, 32'h0000_0000, 1'b1);
    // Immediate store overflow: full local store pushed through full release permeability
    plan_add(ROW_WRITE, tssrs_pkg::REG_REST_PERM, 32'h0000_0000, 1'b0, '0, 1'b0);
    plan_add(ROW_WRITE, tssrs_pkg::REG_REST_IMMEDIATE_CONC, 32'h0000_0000, 1'b0, '0, 1'b0);
    plan_add(ROW_WRITE, tssrs_pkg::REG_REST_LOCAL_CONC, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
    plan_add(ROW_WRITE, tssrs_pkg::REG_RELEASE_PERM, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
    plan_add(ROW_KNOWN, tssrs_pkg::REG_STEP_OVER_VI, 32'h0001_0000, 1'b1, 32'hFFFF_FFFF, 1'b1);
    // Plain diffusion with moderate settings
    plan_add(ROW_WRITE, tssrs_pkg::REG_STEP_OVER_VI, 32'h0100_0000, 1'b0, '0, 1'b0);
    plan_add(ROW_WRITE, tssrs_pkg::REG_STEP_OVER_VL, 32'h0080_0000, 1'b0, '0, 1'b0);
    plan_add(ROW_WRITE, tssrs_pkg::REG_RELEASE_PERM, 32'h0002_0000, 1'b0, '0, 1'b0);
    plan_add(ROW_WRITE, tssrs_pkg::REG_GLOBAL_PERM, 32'h0000_8000, 1'b0, '0, 1'b0);
    plan_add(ROW_WRITE, tssrs_pkg::REG_GLOBAL_CONC, 32'h0005_0000, 1'b0, '0, 1'b0);
    plan_add(ROW_WRITE, tssrs_pkg::REG_REST_IMMEDIATE_CONC, 32'h0001_0000, 1'b0, '0, 1'b0);
    plan_add(ROW_WRITE, tssrs_pkg::REG_REST_LOCAL_CONC, 32'h0003_0000, 1'b0, '0, 1'b0);
    plan_add(ROW_WRITE, tssrs_pkg::REG_REST_PERM, 32'h0000_4000, 1'b0, '0, 1'b0);
    plan_add(ROW_BEAT, tssrs_pkg::REG_STEP_OVER_VI, 32'h0001_0000, 1'b1, '0, 1'b0);
    plan_add(ROW_BEAT, tssrs_pkg::REG_STEP_OVER_VI, 32'h0002_0000, 1'b0, '0, 1'b0);
    plan_add(ROW_BEAT, tssrs_pkg::REG_STEP_OVER_VI, 32'h0000_0000, 1'b0, '0, 1'b0);
    plan_add(ROW_BEAT, tssrs_pkg::REG_STEP_OVER_VI, 32'h7FFF_FFFF, 1'b0, '0, 1'b0);
    plan_add(ROW_BEAT, tssrs_pkg::REG_STEP_OVER_VI, 32'h8000_0000, 1'b0, '0, 1'b0);
    plan_add(ROW_BEAT, tssrs_pkg::REG_STEP_OVER_VI, 32'h0000_FFFF, 1'b0, '0, 1'b0);
    // A rest write leaves the stores alone until the next restart
    plan_add(ROW_WRITE, tssrs_pkg::REG_REST_LOCAL_CONC, 32'h0009_0000, 1'b0, '0, 1'b0);
    plan_add(ROW_BEAT, tssrs_pkg::REG_STEP_OVER_VI, 32'h0001_8000, 1'b0, '0, 1'b0);
    plan_add(ROW_BEAT, tssrs_pkg::REG_STEP_OVER_VI, 32'h0001_8000, 1'b1, '0, 1'b0);
    // Empty global store with full local gain: local store drains hard
    plan_add(ROW_WRITE, tssrs_pkg::REG_GLOBAL_CONC, 32'h0000_0000, 1'b0, '0, 1'b0);
    plan_add(ROW_WRITE, tssrs_pkg::REG_STEP_OVER_VL, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
    plan_add(ROW_BEAT, tssrs_pkg::REG_STEP_OVER_VI, 32'h0001_0000, 1'b0, '0, 1'b0);
    plan_add(ROW_BEAT, tssrs_pkg::REG_STEP_OVER_VI, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
    plan_add(ROW_BEAT, tssrs_pkg::REG_STEP_OVER_VI, 32'hAAAA_AAAA, 1'b1, '0, 1'b0);
    plan_add(ROW_BEAT, tssrs_pkg::REG_STEP_OVER_VI, 32'h5555_5555, 1'b0, '0, 1'b0);

    rst_n = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part
    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_WRITE) begin
        wait_drained();
        write_reg(row.idx, row.word);
      end else begin
        send_beat(row.word, row.restart, row.kind == ROW_KNOWN, row.known);
      end
    end

    // Random phases: fresh settings, then a run that normally opens with a restart
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      wait_drained();
      style = cfg_style_t'($urandom_range(0, 2));
      for (int k = 0; k < 8; k++) begin
        case (style)
          STYLE_TAME: begin
            if (tssrs_pkg::reg_idx_t'(k) == tssrs_pkg::REG_STEP_OVER_VI ||
                tssrs_pkg::reg_idx_t'(k) == tssrs_pkg::REG_STEP_OVER_VL)
              word = $urandom_range(0, 32'h0400_0000);
            else
              word = $urandom_range(0, 32'h0010_0000);
          end
          STYLE_EXTREME: begin
            case ($urandom_range(0, 4))
              0: word = 32'h0000_0000;
              1: word = 32'hFFFF_FFFF;
              2: word = 32'h8000_0000;
              3: word = 32'h0001_0000;
              default: word = $urandom;
            endcase
          end
          default: word = $urandom;
        endcase
        write_reg(tssrs_pkg::reg_idx_t'(k), word);
      end
      // the first random run meets one long receiver hold-off
      if (sent == 0) hold_req = 1'b1;
      calm = ($urandom_range(0, 4) == 0);
      phase_len = $urandom_range(20, 80);
      for (int k = 0; k < phase_len && sent < RANDOM_BEATS; k++) begin
        if (sent >= RANDOM_BEATS - 100) calm = 1'b1;
        // a run of idle bursts can outlast a step, so the next beat lands at any phase
        if (!calm && $urandom_range(0, 3) == 0) begin
          gap = 0;
          repeat ($urandom_range(1, 3)) gap += $urandom_range(1, 5);
          @(negedge clk);
          in_tvalid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
        case ($urandom_range(0, 19))
          0, 1, 2: begin
            case ($urandom_range(0, 5))
              0: word = 32'h0000_0000;
              1: word = 32'h0000_0001;
              2: word = 32'hFFFF_FFFF;
              3: word = 32'h8000_0000;
              4: word = 32'h0000_FFFF;
              default: word = 32'h0001_0000;
            endcase
          end
          3, 4, 5, 6, 7, 8, 9: word = $urandom;
          default: word = $urandom_range(0, 32'h0004_0000);
        endcase
        if (k == 0) restart = ($urandom_range(0, 5) != 0);
        else restart = ($urandom_range(0, 24) == 0);
        send_beat(word, restart, 1'b0, '0);
        sent++;
      end
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
